>>> rtl/swept_aabb_collision_test_unit_defines.svh
// ----------------------------------------------------------------------------
// Swept box collision test: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef SWEPT_AABB_COLLISION_TEST_UNIT_DEFINES_SVH
`define SWEPT_AABB_COLLISION_TEST_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SAABB_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked a fixed number of cycles later.
`define SAABB_ASSERT_LAT(name, ante, lat, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##lat (cons)) \
    else $error(msg);

`endif

>>> rtl/saabb_pkg.sv
// ----------------------------------------------------------------------------
// Swept box collision test package
// Field widths, register map and item types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package saabb_pkg;

  localparam int COORD_W   = 24;
  localparam int TIME_W    = 24;
  localparam int TIME_INT  = 4;
  localparam int TIME_FRAC = TIME_W - TIME_INT;
  localparam int ADDR_W    = 3;

  localparam int FRAME_TIME_RESET = 17476;

  // Register index, byte address is 4 * index.
  localparam logic [ADDR_W-3:0] REG_FRAME_TIME = 1'b0;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_min_x;
    logic signed [COORD_W-1:0] a_min_y;
    logic signed [COORD_W-1:0] a_max_x;
    logic signed [COORD_W-1:0] a_max_y;
    logic signed [COORD_W-1:0] b_min_x;
    logic signed [COORD_W-1:0] b_min_y;
    logic signed [COORD_W-1:0] b_max_x;
    logic signed [COORD_W-1:0] b_max_y;
    logic signed [COORD_W-1:0] a_vel_x;
    logic signed [COORD_W-1:0] a_vel_y;
    logic signed [COORD_W-1:0] b_vel_x;
    logic signed [COORD_W-1:0] b_vel_y;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic [TIME_W-1:0] time_first;
  } res_t;

endpackage

>>> rtl/saabb_div.sv
// ----------------------------------------------------------------------------
// Pipelined saturating divider
// q = min(floor(gap * 2^TIME_FRAC / mag), 2^TIME_W - 1), one quotient bit per
// stage, restoring; takes a new operand pair every cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module saabb_div (
  input  logic                            clk_i,
  input  logic [saabb_pkg::COORD_W-1:0]   gap_i,
  input  logic [saabb_pkg::COORD_W:0]     mag_i,
  output logic [saabb_pkg::TIME_W-1:0]    q_o
);

  localparam int CW = saabb_pkg::COORD_W;
  localparam int TW = saabb_pkg::TIME_W;
  localparam int NS = TW + 1;
  localparam int TI = saabb_pkg::TIME_INT;
  localparam int TF = saabb_pkg::TIME_FRAC;

  logic          sat_q [NS];
  logic [CW-1:0] r_q   [NS];
  logic [CW:0]   mag_q [NS];
  logic [TW-1:0] n_q   [NS];
  logic [TW-1:0] qt_q  [NS];

  logic sat_d;
  // Quotient overflows TW bits exactly when gap >= mag * 2^TIME_INT.
  assign sat_d = {{TI{1'b0}}, 1'b0, gap_i} >= {mag_i, {TI{1'b0}}};

  always_ff @(posedge clk_i) begin
    sat_q[0] <= sat_d;
    r_q[0]   <= CW'(gap_i >> TI);
    mag_q[0] <= mag_i;
    n_q[0]   <= {gap_i[TI-1:0], {TF{1'b0}}};
    qt_q[0]  <= '0;
  end

  for (genvar k = 1; k < NS; k++) begin : g_stage
    logic [CW:0] rr;
    logic [CW:0] diff;
    logic        ge;
    assign rr   = {r_q[k-1], n_q[k-1][TW-1]};
    assign diff = rr - mag_q[k-1];
    assign ge   = rr >= mag_q[k-1];

    always_ff @(posedge clk_i) begin
      sat_q[k] <= sat_q[k-1];
      mag_q[k] <= mag_q[k-1];
      r_q[k]   <= ge ? diff[CW-1:0] : rr[CW-1:0];
      n_q[k]   <= n_q[k-1] << 1;
      qt_q[k]  <= {qt_q[k-1][TW-2:0], ge};
    end
  end

  assign q_o = sat_q[NS-1] ? '1 : qt_q[NS-1];

endmodule

>>> rtl/swept_aabb_collision_test_unit.sv
// ----------------------------------------------------------------------------
// Swept 2D box collision test unit
// Relative-motion swept box test, fixed point, one result per item.
// ----------------------------------------------------------------------------
// One item (two Q16.8 boxes and their velocities) is taken on any cycle with
// start high; busy never rises, so a new item may follow every cycle. Each
// item gives exactly one result, shown for a single cycle with result_valid_o
// high, after the input, compare, select, divider, min/max and result
// registers. The receiver cannot hold results off and none is dropped. Most
// of the pipeline is the four dividers (entry and exit gap over |v| on each
// axis), which resolve one quotient bit per stage. time_first is Q4.20
// seconds and reads 0 when hit is low. frame_time is written over the APB
// port at byte address 0; write it only while no item is in flight.
`timescale 1ns / 1ps

`include "swept_aabb_collision_test_unit_defines.svh"

module swept_aabb_collision_test_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // item channel
  input  logic                              start,
  output logic                              busy,
  input  saabb_pkg::in_t                    in_i,
  output logic                              result_valid_o,
  output saabb_pkg::res_t                   res_o,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [saabb_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int CW       = saabb_pkg::COORD_W;
  localparam int TW       = saabb_pkg::TIME_W;
  localparam int NS       = TW + 1;           // divider depth
  localparam int PIPE_LAT = TW + 6;

  typedef struct packed {
    logic signed [CW:0] v;
    logic               c1;   // amin > bmax
    logic               c2;   // bmin > amax
    logic               c3;   // bmax > amin
    logic               c4;   // amax > bmin
    logic [CW-1:0]      en_p;
    logic [CW-1:0]      ex_p;
    logic [CW-1:0]      en_n;
    logic [CW-1:0]      ex_n;
  } pre_t;

  typedef struct packed {
    logic          rej;
    logic          zero;
    logic [CW-1:0] gap_en;
    logic [CW-1:0] gap_ex;
    logic [CW:0]   mag;
  } ax_t;

  typedef struct packed {
    logic rej_x;
    logic rej_y;
    logic zero_x;
    logic zero_y;
  } side_t;

  // Compares and edge gaps for one axis.
  function automatic pre_t axis_pre(logic signed [CW-1:0] amin, logic signed [CW-1:0] amax,
                                    logic signed [CW-1:0] bmin, logic signed [CW-1:0] bmax,
                                    logic signed [CW-1:0] va, logic signed [CW-1:0] vb);
    pre_t p;
    logic signed [CW:0] d;
    p.v  = (CW+1)'(va) - (CW+1)'(vb);
    p.c1 = amin > bmax;
    p.c2 = bmin > amax;
    p.c3 = bmax > amin;
    p.c4 = amax > bmin;
    d      = (CW+1)'(bmin) - (CW+1)'(amax);
    p.en_p = d[CW-1:0];
    d      = (CW+1)'(bmax) - (CW+1)'(amin);
    p.ex_p = d[CW-1:0];
    d      = (CW+1)'(amin) - (CW+1)'(bmax);
    p.en_n = d[CW-1:0];
    d      = (CW+1)'(amax) - (CW+1)'(bmin);
    p.ex_n = d[CW-1:0];
    return p;
  endfunction

  // Pick gaps by direction of motion; with motion, a gap of 0 divides to 0.
  function automatic ax_t axis_sel(pre_t p);
    ax_t a;
    a.zero   = 1'b0;
    a.gap_en = '0;
    a.gap_ex = '0;
    a.mag    = p.v[CW] ? -p.v : p.v;
    priority if (p.v == '0) begin
      // no motion: entry 0, divider saturates exit (mag is 0)
      a.rej  = p.c1 | p.c2;
      a.zero = 1'b1;
    end else if (!p.v[CW]) begin
      a.rej = p.c1;
      if (p.c2) a.gap_en = p.en_p;
      if (p.c3) a.gap_ex = p.ex_p;
    end else begin
      a.rej = p.c2;
      if (p.c1) a.gap_en = p.en_n;
      if (p.c4) a.gap_ex = p.ex_n;
    end
    return a;
  endfunction

  // ---------------- configuration ----------------
  logic [TW-1:0] frame_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
               && (paddr[saabb_pkg::ADDR_W-1:2] == saabb_pkg::REG_FRAME_TIME);
  assign prdata = (paddr[saabb_pkg::ADDR_W-1:2] == saabb_pkg::REG_FRAME_TIME)
                ? 32'(frame_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= TW'(saabb_pkg::FRAME_TIME_RESET);
    end else if (cfg_wr) begin
      frame_q <= pwdata[TW-1:0];
    end
  end

  // ---------------- stage 1: input register ----------------
  assign busy = 1'b0;

  logic           s1_vld_q;
  saabb_pkg::in_t s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else         s1_vld_q <= start;
  end

  always_ff @(posedge clk_i) begin
    if (start) s1_q <= in_i;
  end

  // ---------------- stage 2: relative velocity, compares, gaps ----------
  logic s2_vld_q;
  pre_t s2x_q, s2y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else         s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    s2x_q <= axis_pre(s1_q.a_min_x, s1_q.a_max_x, s1_q.b_min_x, s1_q.b_max_x,
                      s1_q.a_vel_x, s1_q.b_vel_x);
    s2y_q <= axis_pre(s1_q.a_min_y, s1_q.a_max_y, s1_q.b_min_y, s1_q.b_max_y,
                      s1_q.a_vel_y, s1_q.b_vel_y);
  end

  // ---------------- stage 3: direction select, |v| ----------------
  logic s3_vld_q;
  ax_t  s3x_q, s3y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_vld_q <= 1'b0;
    else         s3_vld_q <= s2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    s3x_q <= axis_sel(s2x_q);
    s3y_q <= axis_sel(s2y_q);
  end

  // ---------------- dividers ----------------
  logic [TW-1:0] qen_x, qex_x, qen_y, qex_y;

  saabb_div u_div_en_x (.clk_i, .gap_i(s3x_q.gap_en), .mag_i(s3x_q.mag), .q_o(qen_x));
  saabb_div u_div_ex_x (.clk_i, .gap_i(s3x_q.gap_ex), .mag_i(s3x_q.mag), .q_o(qex_x));
  saabb_div u_div_en_y (.clk_i, .gap_i(s3y_q.gap_en), .mag_i(s3y_q.mag), .q_o(qen_y));
  saabb_div u_div_ex_y (.clk_i, .gap_i(s3y_q.gap_ex), .mag_i(s3y_q.mag), .q_o(qex_y));

  // sideband travels alongside the divider stages
  logic  side_vld_q [NS];
  side_t side_q     [NS];
  side_t side_d;

  assign side_d = '{rej_x: s3x_q.rej, rej_y: s3y_q.rej,
                    zero_x: s3x_q.zero, zero_y: s3y_q.zero};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) side_vld_q[k] <= 1'b0;
    end else begin
      side_vld_q[0] <= s3_vld_q;
      for (int k = 1; k < NS; k++) side_vld_q[k] <= side_vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int k = 1; k < NS; k++) side_q[k] <= side_q[k-1];
  end

  // ---------------- latest entry, earliest exit ----------------
  logic [TW-1:0] ent_x, ent_y;
  logic          sc_vld_q, sc_rej_q;
  logic [TW-1:0] sc_ent_q, sc_ext_q;

  assign ent_x = side_q[NS-1].zero_x ? '0 : qen_x;
  assign ent_y = side_q[NS-1].zero_y ? '0 : qen_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sc_vld_q <= 1'b0;
    else         sc_vld_q <= side_vld_q[NS-1];
  end

  always_ff @(posedge clk_i) begin
    sc_rej_q <= side_q[NS-1].rej_x | side_q[NS-1].rej_y;
    sc_ent_q <= (ent_x > ent_y) ? ent_x : ent_y;
    sc_ext_q <= (qex_x < qex_y) ? qex_x : qex_y;
  end

  // ---------------- decision and result register ----------------
  logic            hit_d;
  logic            res_vld_q;
  saabb_pkg::res_t res_q;

  assign hit_d = !sc_rej_q && (sc_ent_q <= sc_ext_q) && (sc_ent_q <= frame_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_vld_q <= 1'b0;
    else         res_vld_q <= sc_vld_q;
  end

  always_ff @(posedge clk_i) begin
    res_q.hit        <= hit_d;
    res_q.time_first <= hit_d ? sc_ent_q : '0;
  end

  assign result_valid_o = res_vld_q;
  assign res_o          = res_q;

  // ---------------- assertions ----------------
  `SAABB_ASSERT_LAT(a_fixed_latency, start && !busy, PIPE_LAT, result_valid_o, "result missing after fixed latency")
  `SAABB_ASSERT_NOW(a_hit_in_frame, result_valid_o && res_o.hit, res_o.time_first <= frame_q, "hit time beyond frame")
  `SAABB_ASSERT_NOW(a_miss_zero, result_valid_o && !res_o.hit, res_o.time_first == '0, "miss with nonzero time")

endmodule
